FILE: hdl/udrf_pkg.sv
// Shared types and constants for the dual-ring UART FIFO block.
// No dependencies; every other file of the block but udrf_ram refers to this package.
package udrf_pkg;

    localparam int RX_DEPTH = 256;
    localparam int TX_DEPTH = 256;
    localparam int RX_AW    = $clog2(RX_DEPTH);
    localparam int TX_AW    = $clog2(TX_DEPTH);
    localparam int DATA_W   = 8;
    localparam int CMD_W    = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_RX_BYTE  = 2'd0,
        CMD_POP      = 2'd1,
        CMD_PUSH     = 2'd2,
        CMD_TX_READY = 2'd3
    } t_cmd;

    // Result fields that travel from the decode stage to the output register.
    typedef struct packed {
        logic from_tx;
        logic data_valid;
        logic accepted;
        logic rx_notify;
        logic tx_irq_enabled;
    } t_result_ctl;

endpackage

FILE: hdl/udrf_stream_if.sv
// Valid/ready channel interfaces for the command input and the result output.
// Depends on udrf_pkg for the field widths.
interface udrf_in_if;
    logic                             valid;
    logic                             ready;
    logic [udrf_pkg::CMD_W-1:0]       command;
    logic [udrf_pkg::DATA_W-1:0]      data_in;

    modport source (output valid, output command, output data_in, input ready);
    modport sink   (input valid, input command, input data_in, output ready);
endinterface

interface udrf_out_if;
    logic                             valid;
    logic                             ready;
    logic [udrf_pkg::DATA_W-1:0]      data_out;
    logic                             data_valid;
    logic                             accepted;
    logic                             rx_notify;
    logic                             tx_irq_enabled;

    modport source (output valid, output data_out, output data_valid, output accepted,
                    output rx_notify, output tx_irq_enabled, input ready);
    modport sink   (input valid, input data_out, input data_valid, input accepted,
                    input rx_notify, input tx_irq_enabled, output ready);
endinterface

FILE: hdl/udrf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module udrf_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/uart_dual_ring_fifo.sv
// Top level of the dual-ring UART FIFO: pointer control, command decode, output register.
// Depends on udrf_pkg, udrf_stream_if.sv and udrf_ram.
//
// Usage. Commands arrive on i_in, one transaction per command: a received byte, a pop of
// the receive ring, a push into the transmit ring, or a transmitter-ready event. Every
// command produces exactly one result transaction on o_out, in command order.
// i_cfg_we with i_cfg_wdata sets the notify enable; write it only while the block is idle.
//
// Operation. A command is decoded in the cycle it is accepted: at that edge the ring
// pointers and the transmit interrupt enable update, a stored byte is written to its
// ring RAM, a pop or transmit read is registered by the RAM, and the result enters the
// decode stage register. The result and the RAM read data then move into the output
// register when it is free. One command per clock is sustained while the receiver does
// not stall o_out, since each RAM read port is used once per command and the pointers
// move at accept time.
//
// Each ring keeps one slot empty, so it holds at most depth minus one bytes. The RAMs
// need no clearing: only entries between the read and write pointers are ever read.
// Reset (synchronous, active low) clears the pointers, the interrupt enable, the notify
// enable and both valid flags of the pipeline. When the receiver stalls o_out, the result
// holds, the decode stage fills, and i_in.ready then drops until the output drains.
module uart_dual_ring_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    udrf_in_if.sink                       i_in,
    udrf_out_if.source                    o_out,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_wdata
);

    localparam int RX_AW  = udrf_pkg::RX_AW;
    localparam int TX_AW  = udrf_pkg::TX_AW;
    localparam int DATA_W = udrf_pkg::DATA_W;

    // Ring pointers and control state.
    logic [RX_AW-1:0] r_rx_wr, r_rx_rd;
    logic [TX_AW-1:0] r_tx_wr, r_tx_rd;
    logic [RX_AW-1:0] rx_wr_nxt, rx_rd_nxt;
    logic [TX_AW-1:0] tx_wr_nxt, tx_rd_nxt;
    logic             r_tx_irq, n_tx_irq;
    logic             r_notify_en;

    // Decode stage and output register.
    logic                   r_s1_valid;
    udrf_pkg::t_result_ctl  r_s1_ctl, n_s1_ctl;
    logic                   r_out_valid;
    udrf_pkg::t_result_ctl  r_out_ctl;
    logic [DATA_W-1:0]      r_out_data;

    logic              accept, out_free, s1_move;
    logic              rx_full, rx_empty, tx_full, tx_empty;
    logic              rx_we, rx_re, tx_we, tx_re;
    logic [DATA_W-1:0] rx_rdata, tx_rdata;
    udrf_pkg::t_cmd    cmd;

    assign cmd = udrf_pkg::t_cmd'(i_in.command);

    // Advance modulo depth; depth need not be a power of two.
    assign rx_wr_nxt = (r_rx_wr == RX_AW'(udrf_pkg::RX_DEPTH - 1)) ? '0 : r_rx_wr + RX_AW'(1);
    assign rx_rd_nxt = (r_rx_rd == RX_AW'(udrf_pkg::RX_DEPTH - 1)) ? '0 : r_rx_rd + RX_AW'(1);
    assign tx_wr_nxt = (r_tx_wr == TX_AW'(udrf_pkg::TX_DEPTH - 1)) ? '0 : r_tx_wr + TX_AW'(1);
    assign tx_rd_nxt = (r_tx_rd == TX_AW'(udrf_pkg::TX_DEPTH - 1)) ? '0 : r_tx_rd + TX_AW'(1);

    assign rx_full  = (rx_wr_nxt == r_rx_rd);
    assign rx_empty = (r_rx_rd == r_rx_wr);
    assign tx_full  = (tx_wr_nxt == r_tx_rd);
    assign tx_empty = (r_tx_rd == r_tx_wr);

    // The output register is free when empty or being drained this cycle. The decode
    // stage can take a new command when it is empty or is moving into the output.
    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_move    = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || out_free;
    assign accept     = i_in.valid && i_in.ready;

    // Command decode: every decision is made from the pointers at acceptance time.
    always_comb begin
        rx_we    = 1'b0;
        rx_re    = 1'b0;
        tx_we    = 1'b0;
        tx_re    = 1'b0;
        n_tx_irq = r_tx_irq;
        n_s1_ctl = '0;
        case (cmd)
            udrf_pkg::CMD_RX_BYTE: begin
                rx_we              = !rx_full;
                n_s1_ctl.accepted  = !rx_full;
                n_s1_ctl.rx_notify = r_notify_en;
            end
            udrf_pkg::CMD_POP: begin
                rx_re               = !rx_empty;
                n_s1_ctl.data_valid = !rx_empty;
            end
            udrf_pkg::CMD_PUSH: begin
                tx_we             = !tx_full;
                n_s1_ctl.accepted = !tx_full;
                if (!tx_full) begin
                    n_tx_irq = 1'b1;
                end
            end
            udrf_pkg::CMD_TX_READY: begin
                if (r_tx_irq) begin
                    if (tx_empty) begin
                        n_tx_irq = 1'b0;
                    end else begin
                        tx_re               = 1'b1;
                        n_s1_ctl.data_valid = 1'b1;
                        n_s1_ctl.from_tx    = 1'b1;
                    end
                end
            end
            default: begin
                n_s1_ctl = '0;
            end
        endcase
        n_s1_ctl.tx_irq_enabled = n_tx_irq;
    end

    udrf_ram #(.DEPTH(udrf_pkg::RX_DEPTH), .WIDTH(DATA_W)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (accept && rx_we),
        .i_waddr (r_rx_wr),
        .i_wdata (i_in.data_in),
        .i_re    (accept && rx_re),
        .i_raddr (r_rx_rd),
        .o_rdata (rx_rdata)
    );

    udrf_ram #(.DEPTH(udrf_pkg::TX_DEPTH), .WIDTH(DATA_W)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (accept && tx_we),
        .i_waddr (r_tx_wr),
        .i_wdata (i_in.data_in),
        .i_re    (accept && tx_re),
        .i_raddr (r_tx_rd),
        .o_rdata (tx_rdata)
    );

    // Control state: pointers, enables and pipeline valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_wr     <= '0;
            r_rx_rd     <= '0;
            r_tx_wr     <= '0;
            r_tx_rd     <= '0;
            r_tx_irq    <= 1'b0;
            r_notify_en <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_notify_en <= i_cfg_wdata;
            end
            if (accept) begin
                if (rx_we) begin
                    r_rx_wr <= rx_wr_nxt;
                end
                if (rx_re) begin
                    r_rx_rd <= rx_rd_nxt;
                end
                if (tx_we) begin
                    r_tx_wr <= tx_wr_nxt;
                end
                if (tx_re) begin
                    r_tx_rd <= tx_rd_nxt;
                end
                r_tx_irq <= n_tx_irq;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers. The RAM read data is stable while the decode stage waits,
    // because no new read is issued until the stage moves on.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ctl <= n_s1_ctl;
        end
        if (s1_move) begin
            r_out_ctl <= r_s1_ctl;
            if (!r_s1_ctl.data_valid) begin
                r_out_data <= '0;
            end else if (r_s1_ctl.from_tx) begin
                r_out_data <= tx_rdata;
            end else begin
                r_out_data <= rx_rdata;
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.data_out       = r_out_data;
    assign o_out.data_valid     = r_out_ctl.data_valid;
    assign o_out.accepted       = r_out_ctl.accepted;
    assign o_out.rx_notify      = r_out_ctl.rx_notify;
    assign o_out.tx_irq_enabled = r_out_ctl.tx_irq_enabled;

endmodule

FILE: hdl/udrf_checker.sv
// Port-level checks on the dual-ring UART FIFO, attached to the top level by a bind.
// Depends on udrf_pkg and uart_dual_ring_fifo.
module udrf_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [udrf_pkg::DATA_W-1:0]  i_data_out,
    input  logic                         i_data_valid,
    input  logic                         i_accepted,
    input  logic                         i_rx_notify
);

    // A result held back by the receiver keeps its byte.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_data_out))
        else $error("result changed while stalled");

    // No byte is shown without data_valid.
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_data_valid |-> i_data_out == '0)
        else $error("data_out not zero without data_valid");

    // A stored byte and a delivered byte never come from the same transaction.
    a_acc_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_accepted |-> !i_data_valid)
        else $error("accepted and data_valid together");

    // Notify only comes with a received byte, which never delivers data.
    a_notify_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_rx_notify |-> !i_data_valid)
        else $error("rx_notify with data_valid");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind uart_dual_ring_fifo udrf_checker u_udrf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_data_out   (o_out.data_out),
    .i_data_valid (o_out.data_valid),
    .i_accepted   (o_out.accepted),
    .i_rx_notify  (o_out.rx_notify)
);

FILE: verif/udrf_ring_checker.sv
`timescale 1ns / 100ps
// Checker for the dual-ring UART FIFO: watches both channels and the notify enable port.
// It predicts every result transaction and compares it. Depends on udrf_pkg and udrf_stream_if.sv.
module udrf_ring_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    udrf_in_if    in_mon,
    udrf_out_if   out_mon,
    input  logic  i_cfg_we,
    input  logic  i_cfg_wdata,
    output int    o_fail_count,
    output int    o_pending
);
    import udrf_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] data_out;
        logic              data_valid;
        logic              accepted;
        logic              rx_notify;
        logic              tx_irq_enabled;
    } t_ring_result;

    logic [DATA_W-1:0] rx_bytes [RX_DEPTH];
    logic [DATA_W-1:0] tx_bytes [TX_DEPTH];
    int                rx_head, rx_tail, tx_head, tx_tail;
    logic              tx_irq_on;
    logic              notify_on;
    t_ring_result      awaited_results [$];
    int                fail_count;

    function automatic int ring_next(input int ptr, input int depth);
        return (ptr + 1 >= depth) ? 0 : ptr + 1;
    endfunction

    // Applies one command to the shadow rings and returns the result it must produce.
    function automatic t_ring_result predict_ring_result(input t_cmd cmd,
                                                         input logic [DATA_W-1:0] din);
        t_ring_result res;
        int           nxt;
        res = '0;
        case (cmd)
            CMD_RX_BYTE: begin
                nxt = ring_next(rx_head, RX_DEPTH);
                if (nxt != rx_tail) begin
                    rx_bytes[rx_head] = din;
                    rx_head = nxt;
                    res.accepted = 1'b1;
                end
                res.rx_notify = notify_on;
            end
            CMD_POP: begin
                if (rx_tail != rx_head) begin
                    res.data_out = rx_bytes[rx_tail];
                    res.data_valid = 1'b1;
                    rx_tail = ring_next(rx_tail, RX_DEPTH);
                end
            end
            CMD_PUSH: begin
                nxt = ring_next(tx_head, TX_DEPTH);
                if (nxt != tx_tail) begin
                    tx_bytes[tx_head] = din;
                    tx_head = nxt;
                    res.accepted = 1'b1;
                    tx_irq_on = 1'b1;
                end
            end
            default: begin
                if (tx_irq_on) begin
                    if (tx_tail == tx_head) begin
                        tx_irq_on = 1'b0;
                    end else begin
                        res.data_out = tx_bytes[tx_tail];
                        res.data_valid = 1'b1;
                        tx_tail = ring_next(tx_tail, TX_DEPTH);
                    end
                end
            end
        endcase
        res.tx_irq_enabled = tx_irq_on;
        return res;
    endfunction

    initial begin
        fail_count = 0;
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin : watch
        t_ring_result got;
        t_ring_result want;
        if (!i_rst_n) begin
            rx_head = 0;
            rx_tail = 0;
            tx_head = 0;
            tx_tail = 0;
            tx_irq_on = 1'b0;
            notify_on = 1'b0;
            awaited_results.delete();
        end else begin
            if (i_cfg_we) begin
                notify_on = i_cfg_wdata;
            end
            // A result leaves after the decode and output registers, so the output side is
            // handled before the command accepted at this same edge is queued.
            if (out_mon.valid && out_mon.ready) begin
                got = '{data_out: out_mon.data_out, data_valid: out_mon.data_valid,
                        accepted: out_mon.accepted, rx_notify: out_mon.rx_notify,
                        tx_irq_enabled: out_mon.tx_irq_enabled};
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result: data_out=%02h data_valid=%0b accepted=%0b rx_notify=%0b tx_irq_enabled=%0b",
                             $time, got.data_out, got.data_valid, got.accepted,
                             got.rx_notify, got.tx_irq_enabled);
                    fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch: expected data_out=%02h data_valid=%0b accepted=%0b rx_notify=%0b tx_irq_enabled=%0b, actual data_out=%02h data_valid=%0b accepted=%0b rx_notify=%0b tx_irq_enabled=%0b",
                                 $time, want.data_out, want.data_valid, want.accepted,
                                 want.rx_notify, want.tx_irq_enabled, got.data_out,
                                 got.data_valid, got.accepted, got.rx_notify,
                                 got.tx_irq_enabled);
                        fail_count++;
                    end
                end
            end
            if (in_mon.valid && in_mon.ready) begin
                awaited_results.push_back(predict_ring_result(t_cmd'(in_mon.command),
                                                              in_mon.data_in));
            end
        end
        o_pending <= awaited_results.size();
        o_fail_count <= fail_count;
    end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// Testbench top for the dual-ring UART FIFO: clock, reset, command stimulus and the verdict.
// Depends on udrf_pkg, udrf_stream_if.sv, uart_dual_ring_fifo and udrf_ring_checker.
module tb;
    import udrf_pkg::*;

    // Hard ceiling on the run. A normal run ends well within it even with the heaviest
    // idling, so this only catches a hung handshake.
    localparam int CYCLE_LIMIT  = 400000;
    // Cycles to let pass after the last result before trusting the block to be idle;
    // the result path runs through the decode stage and the output register.
    localparam int SETTLE_CYCLES = 8;
    // Share, in percent, of random commands forced to the burst's dominant command.
    localparam int BURST_BIAS    = 85;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;
    int   fail_count;
    int   results_pending;
    int   sender_idle_pct;
    int   receiver_stall_pct;

    udrf_in_if  in_ch ();
    udrf_out_if out_ch ();

    uart_dual_ring_fifo DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // The checker sees exactly what the block sees and reports back how many results
    // are still owed and how many comparisons failed.
    udrf_ring_checker ring_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_mon       (in_ch),
        .out_mon      (out_ch),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (results_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // The receiver throttles the output channel with a fresh coin toss every cycle.
    // With a zero stall rate ready simply stays high.
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Watchdog: if the run has not ended by now, something is stuck.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("== FAIL ==");
        $finish;
    end

    // Presents one command and holds it until the block takes it. Valid stays high on
    // return so that back-to-back transactions need no gap; the optional idle cycles
    // in front of the command are the only place this task drops valid.
    task automatic issue_command(input t_cmd cmd, input logic [DATA_W-1:0] data);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.command <= cmd;
        in_ch.data_in <= data;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Stops sending and waits until every outstanding result has been taken.
    task automatic wait_rings_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (results_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The notify enable may only change while the block is idle.
    task automatic write_notify_enable(input logic value);
        wait_rings_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // A burst of random commands biased toward one command. A receive-byte burst fills
    // the receive ring past full so bytes get dropped, a pop burst drains it past empty,
    // and the transmit pair does the same for the transmit ring and its interrupt enable.
    // The rest of the burst is a uniform mix of all four commands.
    task automatic run_burst(input t_cmd dominant, input int count, input int pause_at);
        t_cmd cmd;
        for (int n = 0; n < count; n++) begin
            if (n == pause_at) begin
                wait_rings_idle();
            end
            if ($urandom_range(99) < BURST_BIAS) begin
                cmd = dominant;
            end else begin
                cmd = t_cmd'($urandom_range(3));
            end
            issue_command(cmd, DATA_W'($urandom_range(255)));
        end
    endtask

    initial begin
        in_ch.valid        <= 1'b0;
        in_ch.command      <= CMD_RX_BYTE;
        in_ch.data_in      <= '0;
        i_cfg_we           <= 1'b0;
        i_cfg_wdata        <= 1'b0;
        i_rst_n            <= 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, notify enable still at its reset value. Pops and
        // transmitter-ready events on empty rings come first, while the interrupt
        // enable is off.
        issue_command(CMD_POP, 8'h00);
        issue_command(CMD_TX_READY, 8'hFF);
        // Pushes switch the interrupt enable on; the third ready finds the ring empty
        // and clears it again, and the fourth sees it disabled.
        issue_command(CMD_PUSH, 8'h00);
        issue_command(CMD_PUSH, 8'hFF);
        issue_command(CMD_TX_READY, 8'h00);
        issue_command(CMD_TX_READY, 8'h00);
        issue_command(CMD_TX_READY, 8'h00);
        issue_command(CMD_TX_READY, 8'h00);
        // Received bytes at both extremes and a mixed pattern, then drained past empty.
        issue_command(CMD_RX_BYTE, 8'h00);
        issue_command(CMD_RX_BYTE, 8'hFF);
        issue_command(CMD_RX_BYTE, 8'hA5);
        issue_command(CMD_POP, 8'hFF);
        issue_command(CMD_POP, 8'h00);
        issue_command(CMD_POP, 8'h00);
        issue_command(CMD_POP, 8'h00);
        // With notification on, every received byte raises the notify flag.
        write_notify_enable(1'b1);
        issue_command(CMD_RX_BYTE, 8'h5A);
        issue_command(CMD_RX_BYTE, 8'hC3);
        issue_command(CMD_POP, 8'h00);
        issue_command(CMD_PUSH, 8'h3C);
        issue_command(CMD_TX_READY, 8'h00);
        issue_command(CMD_POP, 8'h00);

        // Random part. Each burst runs under its own idling pattern and notify setting;
        // the write between bursts also makes the sender wait for a full drain.
        write_notify_enable(1'b1);
        run_burst(CMD_RX_BYTE, 330, -1);

        write_notify_enable(1'b0);
        sender_idle_pct = 73;
        run_burst(CMD_POP, 330, -1);

        write_notify_enable(1'b1);
        sender_idle_pct    = 0;
        receiver_stall_pct = 73;
        // Halfway through, the sender stops until every result is back.
        run_burst(CMD_PUSH, 330, 165);

        write_notify_enable(1'b0);
        sender_idle_pct    = 31;
        receiver_stall_pct = 31;
        run_burst(CMD_TX_READY, 330, -1);

        // Let the last results drain, then give the verdict.
        wait_rings_idle();
        if (fail_count == 0 && results_pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
